/* src/text_cat_filter_defines.svh */
// Assertion macros used by the text_cat_filter RTL (tcf_render).
// Needs no other file; taken in by `include where a module asserts.
`ifndef TEXT_CAT_FILTER_DEFINES_SVH
`define TEXT_CAT_FILTER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define TCF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text_cat_filter: check failed");

// Check that a trigger in one cycle implies a condition in the next.
`define TCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_cat_filter: sequence check failed");

`endif

/* src/tcf_pkg.sv */
// Shared types and constants of the text_cat_filter block.
// Has no dependencies; every module refers to it by scoped names.
package tcf_pkg;

  // Line number field: BCD digits, then a tab.
  localparam int NUM_DIGITS = 6;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int NUM_FIELD  = NUM_DIGITS + 1;

  // Rendered byte itself plus up to three marker bytes.
  localparam int SUF_MAX   = 4;
  localparam int SUF_CNT_W = $clog2(SUF_MAX + 1);

  // Longest run of output bytes from one input byte.
  localparam int RUN_MAX = NUM_FIELD + SUF_MAX;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  localparam logic [BCD_W-1:0] BCD_ONE = {{(BCD_W-4){1'b0}}, 4'd1};

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_LET_I  = 8'd73;
  localparam logic [7:0] CH_LET_M  = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_SHIFT  = 8'd64;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One rendered run handed to the output buffer.
  typedef struct packed {
    logic                        load;
    logic [RUN_MAX-1:0][7:0]     bytes;
    logic [CNT_W-1:0]            cnt;
  } run_t;

endpackage

/* src/tcf_cfg_regs.sv */
// Configuration register bank of the text_cat_filter block.
// Depends on tcf_pkg for the register indexes and the cfg_t type.
module tcf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  output tcf_pkg::cfg_t                 cfg_o
);

  tcf_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  // Decode the index of a write transfer.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tcf_pkg::CFG_NUMBER_NONBLANK:  cfg_d.number_nonblank  = cfg_data_i;
        tcf_pkg::CFG_NUMBER_ALL:       cfg_d.number_all       = cfg_data_i;
        tcf_pkg::CFG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_data_i;
        tcf_pkg::CFG_SHOW_ENDS:        cfg_d.show_ends        = cfg_data_i;
        tcf_pkg::CFG_SHOW_TABS:        cfg_d.show_tabs        = cfg_data_i;
        tcf_pkg::CFG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/tcf_render.sv */
// Input register, line state and rendering logic of text_cat_filter.
// Depends on tcf_pkg and the assertion macros in text_cat_filter_defines.svh.
`include "text_cat_filter_defines.svh"

module tcf_render (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcf_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcf_pkg::in_item_t in_item_i,
  input  logic              run_free_i,
  output tcf_pkg::run_t     run_o
);

  localparam int BCD_W = tcf_pkg::BCD_W;
  localparam int ND    = tcf_pkg::NUM_DIGITS;
  localparam int CW    = tcf_pkg::CNT_W;
  localparam logic [BCD_W-1:0] BCD_NINES = {ND{4'h9}};

  // Saturating BCD increment.
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    logic             all9;
    logic [3:0]       d;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < ND; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    if (!all9) begin
      for (int i = 0; i < ND; i++) begin
        d = v[4*i +: 4];
        if (carry) begin
          if (d == 4'd9) begin
            r[4*i +: 4] = 4'd0;
          end else begin
            r[4*i +: 4] = d + 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  logic              in_valid_q;
  tcf_pkg::in_item_t in_q;
  logic              fire;

  logic [BCD_W-1:0]  line_q, line_cur;
  logic [1:0]        blank_q, blank_cur, blank_inc, blank_next;
  logic              at_start_q, start_cur;

  logic [7:0]        c;
  logic              is_nl, is_tab, is_ctl, is_hi_ctl, every;
  logic              sq_cand, drop, do_num, lead;
  logic [3:0]        dig;

  logic [ND-1:0][7:0]                    num;
  logic [tcf_pkg::SUF_MAX-1:0][7:0]      suf;
  logic [tcf_pkg::SUF_CNT_W-1:0]         suf_cnt;
  logic [tcf_pkg::RUN_MAX-1:0][7:0]      bytes;
  logic [CW-1:0]                         num_len;

  // Hold one item in the input register until the output side is free.
  assign fire       = in_valid_q & run_free_i;
  assign in_ready_o = ~in_valid_q | run_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Apply start of file ahead of the byte.
  assign line_cur  = in_q.start_of_file ? tcf_pkg::BCD_ONE : line_q;
  assign blank_cur = in_q.start_of_file ? 2'd0 : blank_q;
  assign start_cur = in_q.start_of_file | at_start_q;

  assign c         = in_q.in_byte;
  assign is_nl     = (c == tcf_pkg::CH_NL);
  assign is_tab    = (c == tcf_pkg::CH_TAB);
  assign is_ctl    = ((c[7:5] == 3'b000) && !is_nl && !is_tab) || (c == tcf_pkg::CH_DEL);
  assign is_hi_ctl = (c[7:5] == 3'b100);
  assign every     = cfg_i.number_all & ~cfg_i.number_nonblank;

  // Count empty lines in a row; drop from the second on.
  assign sq_cand    = cfg_i.squeeze_blank & is_nl & start_cur;
  assign blank_inc  = (blank_cur == 2'd2) ? 2'd2 : blank_cur + 2'd1;
  assign blank_next = sq_cand ? blank_inc : 2'd0;
  assign drop       = sq_cand & (blank_inc == 2'd2);
  assign do_num     = ~drop & start_cur & ((cfg_i.number_nonblank & ~is_nl) | every);

  // Format the line number, blanking leading zeros.
  always_comb begin
    lead = 1'b1;
    dig  = '0;
    num  = '0;
    for (int i = ND - 1; i >= 0; i--) begin
      dig = line_cur[4*i +: 4];
      if (dig != 4'd0 || i == 0) lead = 1'b0;
      num[ND-1-i] = lead ? tcf_pkg::CH_SPACE : tcf_pkg::CH_ZERO + {4'd0, dig};
    end
  end

  // Render the byte itself with its markers.
  always_comb begin
    suf     = '0;
    suf_cnt = tcf_pkg::SUF_CNT_W'(1);
    suf[0]  = c;
    if (cfg_i.show_tabs && is_tab) begin
      suf[0]  = tcf_pkg::CH_CARET;
      suf[1]  = tcf_pkg::CH_LET_I;
      suf_cnt = tcf_pkg::SUF_CNT_W'(2);
    end else if (cfg_i.show_ends && is_nl) begin
      suf[0]  = tcf_pkg::CH_DOLLAR;
      suf[1]  = c;
      suf_cnt = tcf_pkg::SUF_CNT_W'(2);
    end else if (cfg_i.show_nonprinting && is_ctl) begin
      suf[0]  = tcf_pkg::CH_CARET;
      suf[1]  = (c == tcf_pkg::CH_DEL) ? c - tcf_pkg::CH_SHIFT : c + tcf_pkg::CH_SHIFT;
      suf_cnt = tcf_pkg::SUF_CNT_W'(2);
    end else if (cfg_i.show_nonprinting && is_hi_ctl) begin
      suf[0]  = tcf_pkg::CH_LET_M;
      suf[1]  = tcf_pkg::CH_DASH;
      suf[2]  = tcf_pkg::CH_CARET;
      suf[3]  = c - tcf_pkg::CH_SHIFT;
      suf_cnt = tcf_pkg::SUF_CNT_W'(4);
    end
  end

  // Place the number field ahead of the rendered byte.
  always_comb begin
    bytes = '0;
    if (do_num) begin
      for (int j = 0; j < ND; j++) begin
        bytes[j] = num[j];
      end
      bytes[ND] = tcf_pkg::CH_TAB;
      for (int k = 0; k < tcf_pkg::SUF_MAX; k++) begin
        bytes[tcf_pkg::NUM_FIELD + k] = suf[k];
      end
    end else begin
      for (int k = 0; k < tcf_pkg::SUF_MAX; k++) begin
        bytes[k] = suf[k];
      end
    end
  end

  assign num_len    = do_num ? CW'(tcf_pkg::NUM_FIELD) : '0;
  assign run_o.load  = fire;
  assign run_o.bytes = bytes;
  assign run_o.cnt   = drop ? '0 : num_len + CW'(suf_cnt);

  // Advance the line state as the item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q     <= tcf_pkg::BCD_ONE;
      blank_q    <= 2'd0;
      at_start_q <= 1'b1;
    end else if (fire) begin
      line_q     <= do_num ? bcd_inc(line_cur) : line_cur;
      blank_q    <= blank_next;
      at_start_q <= is_nl;
    end
  end

  `TCF_ASSERT(a_blank_sat, clk_i, rst_ni, blank_q != 2'd3)
  `TCF_ASSERT(a_empty_run_squeezed, clk_i, rst_ni,
              !(fire && run_o.cnt == '0) || (cfg_i.squeeze_blank && is_nl))
  `TCF_ASSERT_NEXT(a_line_saturates, clk_i, rst_ni,
                   line_q == BCD_NINES && !(fire && in_q.start_of_file),
                   line_q == BCD_NINES)
  `TCF_ASSERT_NEXT(a_line_start_tracks, clk_i, rst_ni, fire && !drop,
                   at_start_q == $past(is_nl))

endmodule

/* src/tcf_run_buf.sv */
// Output run buffer of text_cat_filter: holds one rendered run and
// sends it one byte per transfer. Depends on tcf_pkg.
module tcf_run_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcf_pkg::run_t      run_i,
  output logic               run_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcf_pkg::out_item_t out_item_o
);

  localparam int CW = tcf_pkg::CNT_W;
  localparam int RM = tcf_pkg::RUN_MAX;

  logic [RM-1:0][7:0] bytes_q;
  logic [CW-1:0]      cnt_q;
  logic               out_xfer;

  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o & out_ready_i;
  // Free once the last byte of the run goes out.
  assign run_free_o  = (cnt_q == '0) || ((cnt_q == CW'(1)) && out_ready_i);

  assign out_item_o.out_byte    = bytes_q[0];
  assign out_item_o.last_of_run = (cnt_q == CW'(1));

  // Count remaining bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (run_i.load) begin
      cnt_q <= run_i.cnt;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // Load a new run or shift the sent byte out.
  always_ff @(posedge clk_i) begin
    if (run_i.load) begin
      bytes_q <= run_i.bytes;
    end else if (out_xfer) begin
      for (int j = 0; j < RM - 1; j++) begin
        bytes_q[j] <= bytes_q[j+1];
      end
      bytes_q[RM-1] <= '0;
    end
  end

endmodule

/* src/text_cat_filter.sv */
// text_cat_filter: renders a text byte stream with line numbers, blank-line
// squeezing and visible tabs, line ends and control bytes.
// Input: in_valid_i/in_ready_o carry one text byte and a start-of-file flag.
// Output: out_valid_o/out_ready_i carry one rendered byte per transfer, with
// last_of_run set on the final byte caused by an input byte.
// Config: cfg_valid_i/cfg_ready_o write one 1-bit register by index; write
// only while the block is idle. cfg_ready_o is always high.
// Path: an accepted byte waits in the input register, is rendered from there
// and is loaded into the output run buffer once that buffer is free.
// Throughput: one input byte per cycle while out_ready_i is high and it
// renders to a single output byte; a run of n bytes (up to 11) holds the
// input until it drains, one byte per cycle while out_ready_i is high.
// Reset: all options off, line number 1, stream at the start of a line; the
// start-of-file flag restores the same line state ahead of its byte.
// Stall: when out_ready_i is low the run buffer holds, the input register
// fills, and in_ready_o falls until the run drains.
// Depends on tcf_pkg, tcf_cfg_regs, tcf_render and tcf_run_buf.
module text_cat_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tcf_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tcf_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i
);

  tcf_pkg::cfg_t cfg;
  tcf_pkg::run_t run;
  logic          run_free;

  tcf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcf_render u_render (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .run_free_i (run_free),
    .run_o      (run)
  );

  tcf_run_buf u_run_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .run_free_o  (run_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/sv/text_cat_filter_tb.sv */
// Self-checking testbench for text_cat_filter: drives text bytes and register
// writes over valid/ready and checks every rendered byte against a predictor.
// Depends on tcf_pkg and the text_cat_filter RTL.
module text_cat_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 21;

  // Bounds of the printable and meta-control byte ranges, and directed-test letters.
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_META   = 8'd128;
  localparam logic [7:0] CH_HIGH   = 8'd160;
  localparam logic [7:0] CH_LET_LA = 8'd97;
  localparam logic [7:0] CH_LET_LB = 8'd98;
  localparam logic [7:0] CH_LET_LX = 8'd120;
  localparam logic [7:0] CH_LET_A  = 8'd65;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  tcf_pkg::in_item_t             in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  tcf_pkg::out_item_t            out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                          cfg_data = 1'b0;

  // Text bytes waiting to be sent, and rendered characters still expected.
  tcf_pkg::in_item_t  text_q[$];
  tcf_pkg::out_item_t chars_q[$];

  // Predictor copy of the options and the line state.
  tcf_pkg::cfg_t             opts = '0;
  logic [tcf_pkg::BCD_W-1:0] line_bcd = tcf_pkg::BCD_ONE;
  logic [1:0]                blank_run = 2'd0;
  logic [7:0]                prev_char = tcf_pkg::CH_NL;

  int   errors = 0;
  bit   quiet = 1'b0;
  bit   in_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;

  text_cat_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones; none in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Saturating BCD increment of the line counter.
  function automatic logic [tcf_pkg::BCD_W-1:0] bcd_next(
    input logic [tcf_pkg::BCD_W-1:0] v
  );
    logic [tcf_pkg::BCD_W-1:0] r;
    logic                      carry;
    logic                      nines;
    logic [3:0]                d;
    nines = 1'b1;
    for (int i = 0; i < tcf_pkg::NUM_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) nines = 1'b0;
    end
    if (nines) return v;
    carry = 1'b1;
    r = '0;
    for (int i = 0; i < tcf_pkg::NUM_DIGITS; i++) begin
      d = v[4*i +: 4] + {3'd0, carry};
      if (d > 4'd9) begin
        d = 4'd0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      r[4*i +: 4] = d;
    end
    return r;
  endfunction

  // Render one accepted text byte and queue the characters it must produce.
  task automatic render_char(input tcf_pkg::in_item_t it);
    logic [7:0]         c;
    logic [7:0]         run[$];
    logic               at_start;
    logic               every;
    logic               lead;
    logic [3:0]         d;
    tcf_pkg::out_item_t o;
    c = it.in_byte;
    every = opts.number_all && !opts.number_nonblank;
    if (it.start_of_file) begin
      line_bcd = tcf_pkg::BCD_ONE;
      blank_run = 2'd0;
      prev_char = tcf_pkg::CH_NL;
    end
    at_start = (prev_char == tcf_pkg::CH_NL);
    // Drop the second and later empty lines in a row.
    if (opts.squeeze_blank && c == tcf_pkg::CH_NL && at_start) begin
      if (blank_run < 2'd2) blank_run++;
      if (blank_run > 2'd1) return;
    end else begin
      blank_run = 2'd0;
    end
    // Line number field: leading zeros as spaces, then a tab.
    if (at_start && ((opts.number_nonblank && c != tcf_pkg::CH_NL) || every)) begin
      lead = 1'b1;
      for (int i = tcf_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) lead = 1'b0;
        run.push_back(lead ? tcf_pkg::CH_SPACE : tcf_pkg::CH_ZERO + {4'd0, d});
      end
      run.push_back(tcf_pkg::CH_TAB);
      line_bcd = bcd_next(line_bcd);
    end
    if (opts.show_tabs && c == tcf_pkg::CH_TAB) begin
      run.push_back(tcf_pkg::CH_CARET);
      c = tcf_pkg::CH_LET_I;
    end
    if (opts.show_ends && c == tcf_pkg::CH_NL) run.push_back(tcf_pkg::CH_DOLLAR);
    // Caret and meta notation for control bytes.
    if (opts.show_nonprinting) begin
      if ((c < tcf_pkg::CH_SPACE && c != tcf_pkg::CH_NL && c != tcf_pkg::CH_TAB) ||
          c == tcf_pkg::CH_DEL)
        run.push_back(tcf_pkg::CH_CARET);
      if (c >= CH_META && c < CH_HIGH) begin
        run.push_back(tcf_pkg::CH_LET_M);
        run.push_back(tcf_pkg::CH_DASH);
        run.push_back(tcf_pkg::CH_CARET);
      end
      if ((c < tcf_pkg::CH_SPACE || (c > CH_TILDE && c < CH_HIGH)) &&
          c != tcf_pkg::CH_NL && c != tcf_pkg::CH_TAB)
        c = (c > CH_TILDE) ? c - tcf_pkg::CH_SHIFT : c + tcf_pkg::CH_SHIFT;
    end
    run.push_back(c);
    prev_char = c;
    foreach (run[i]) begin
      o.out_byte = run[i];
      o.last_of_run = (i == run.size() - 1);
      chars_q.push_back(o);
    end
  endtask

  // Sender: hold each byte until its transfer, then pause for a random gap.
  always @(negedge clk_i) begin
    logic              nxt_valid;
    tcf_pkg::in_item_t nxt_item;
    nxt_valid = in_valid;
    nxt_item = in_item;
    if (in_taken) begin
      nxt_valid = 1'b0;
      in_taken = 1'b0;
    end
    if (!nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (text_q.size() != 0) begin
        nxt_item = text_q.pop_front();
        nxt_valid = 1'b1;
        send_gap = pick_gap();
      end
    end
    in_valid <= nxt_valid;
    in_item <= nxt_item;
  end

  // Receiver: stall the output at random.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Monitor: track register writes, predict accepted bytes, check results.
  always @(posedge clk_i) begin
    tcf_pkg::out_item_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcf_pkg::CFG_NUMBER_NONBLANK:  opts.number_nonblank = cfg_data;
          tcf_pkg::CFG_NUMBER_ALL:       opts.number_all = cfg_data;
          tcf_pkg::CFG_SQUEEZE_BLANK:    opts.squeeze_blank = cfg_data;
          tcf_pkg::CFG_SHOW_ENDS:        opts.show_ends = cfg_data;
          tcf_pkg::CFG_SHOW_TABS:        opts.show_tabs = cfg_data;
          tcf_pkg::CFG_SHOW_NONPRINTING: opts.show_nonprinting = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        render_char(in_item);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (chars_q.size() == 0) begin
          $error("unexpected output: out_byte %0d, last_of_run %0d",
                 out_item.out_byte, out_item.last_of_run);
          errors++;
        end else begin
          want = chars_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   want.last_of_run, out_item.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_text(input logic [7:0] c, input logic sof);
    tcf_pkg::in_item_t it;
    it.in_byte = c;
    it.start_of_file = sof;
    text_q.push_back(it);
  endtask

  // Wait until every byte is sent and rendered, then let the block settle.
  task automatic wait_drained();
    while (text_q.size() != 0 || in_valid || chars_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tcf_pkg::CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_opts(input tcf_pkg::cfg_t o);
    write_reg(tcf_pkg::CFG_NUMBER_NONBLANK, o.number_nonblank);
    write_reg(tcf_pkg::CFG_NUMBER_ALL, o.number_all);
    write_reg(tcf_pkg::CFG_SQUEEZE_BLANK, o.squeeze_blank);
    write_reg(tcf_pkg::CFG_SHOW_ENDS, o.show_ends);
    write_reg(tcf_pkg::CFG_SHOW_TABS, o.show_tabs);
    write_reg(tcf_pkg::CFG_SHOW_NONPRINTING, o.show_nonprinting);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Printable text, with newlines, tabs, control, delete and high bytes mixed in.
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return tcf_pkg::CH_NL;
    if (r < 20) return tcf_pkg::CH_TAB;
    if (r < 62) return 8'($urandom_range(32, 126));
    if (r < 72) return 8'($urandom_range(0, 31));
    if (r < 76) return tcf_pkg::CH_DEL;
    if (r < 88) return 8'($urandom_range(128, 159));
    return 8'($urandom_range(160, 255));
  endfunction

  // One line of random content, sometimes followed by a run of empty lines.
  task automatic add_line(inout int added);
    int len;
    int nl_count;
    len = $urandom_range(0, 8);
    nl_count = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
    for (int i = 0; i < len; i++) begin
      push_text(rand_char(), $urandom_range(0, 39) == 0);
      added++;
    end
    repeat (nl_count) begin
      push_text(tcf_pkg::CH_NL, 1'b0);
      added++;
    end
  endtask

  initial begin
    tcf_pkg::cfg_t o;
    int            added;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every-line numbering with all display options and squeezing.
    o = '{number_nonblank: 1'b0, number_all: 1'b1, squeeze_blank: 1'b1,
          show_ends: 1'b1, show_tabs: 1'b1, show_nonprinting: 1'b1};
    apply_opts(o);
    push_text(CH_LET_A, 1'b1);      push_text(tcf_pkg::CH_TAB, 1'b0);
    push_text(8'd0, 1'b0);          push_text(8'd31, 1'b0);
    push_text(tcf_pkg::CH_DEL, 1'b0); push_text(CH_META, 1'b0);
    push_text(8'd159, 1'b0);        push_text(CH_HIGH, 1'b0);
    push_text(8'd255, 1'b0);        push_text(tcf_pkg::CH_NL, 1'b0);
    push_text(tcf_pkg::CH_NL, 1'b0); push_text(tcf_pkg::CH_NL, 1'b0);
    push_text(tcf_pkg::CH_NL, 1'b0); push_text(CH_LET_LX, 1'b1);
    push_text(tcf_pkg::CH_NL, 1'b0);
    wait_drained();

    // Directed: both numbering modes on, so only non-empty lines are numbered.
    o = '{number_nonblank: 1'b1, number_all: 1'b1, squeeze_blank: 1'b0,
          show_ends: 1'b0, show_tabs: 1'b0, show_nonprinting: 1'b0};
    apply_opts(o);
    push_text(CH_LET_LA, 1'b1);        push_text(tcf_pkg::CH_NL, 1'b0);
    push_text(tcf_pkg::CH_NL, 1'b0);   push_text(CH_LET_LB, 1'b0);
    push_text(tcf_pkg::CH_TAB, 1'b0);  push_text(tcf_pkg::CH_NL, 1'b0);
    push_text(tcf_pkg::CH_SPACE, 1'b0); push_text(CH_TILDE, 1'b0);
    push_text(8'd1, 1'b0);
    wait_drained();

    // Random phases: all options off, all on, then random settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) o = '0;
      else if (p == 1) o = '1;
      else o = tcf_pkg::cfg_t'(6'($urandom_range(0, 63)));
      quiet = (p == 3);
      apply_opts(o);
      added = 0;
      while (added < PHASE_ITEMS) begin
        add_line(added);
        // In phase 2, hold the sender mid-phase until every pending character has come out.
        if (p == 2 && added >= PHASE_ITEMS / 2 && added < PHASE_ITEMS / 2 + 6)
          wait_drained();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/tcf_pkg.sv
src/tcf_cfg_regs.sv
src/tcf_render.sv
src/tcf_run_buf.sv
src/text_cat_filter.sv
tb/sv/text_cat_filter_tb.sv
